### hdl/isv_pkg.sv
// ============================================================================
// isv_pkg: shared types and constants of the interpolating sample voice
// Request, result and job formats, request codes, register indexes and
// sample format codes used by the front end, the back end and the top level.
// ============================================================================
`default_nettype none

package isv_pkg;

    // Width of the mix accumulators (Q1.23).
    localparam int MIX_W = 24;
    // Width of a sample memory address as carried by a request.
    localparam int ADDR_W = 16;
    // Width of a sample word and of the phase step register.
    localparam int WORD_W = 32;
    // Width of the sample length register.
    localparam int LEN_W = 17;

    localparam logic signed [MIX_W-1:0] MIX_MAX = {1'b0, {(MIX_W-1){1'b1}}};
    localparam logic signed [MIX_W-1:0] MIX_MIN = {1'b1, {(MIX_W-1){1'b0}}};

    // Request codes.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_TRIGGER = 2'd1;
    localparam logic [1:0] REQ_RENDER  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LENGTH = 2'd0;
    localparam logic [1:0] CFG_FORMAT = 2'd1;
    localparam logic [1:0] CFG_STEP   = 2'd2;

    // Sample word formats; the unused code plays as 32-bit words.
    localparam logic [1:0] FMT_S8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0]  LENGTH_RST = '0;
    localparam logic [1:0]        FORMAT_RST = FMT_S16;
    localparam logic [WORD_W-1:0] STEP_RST   = 32'd65536;

    // One request item.
    typedef struct packed {
        logic [1:0]              req_type;
        logic [ADDR_W-1:0]       load_addr;
        logic signed [WORD_W-1:0] load_data;
        logic signed [MIX_W-1:0] mix_in_left;
        logic signed [MIX_W-1:0] mix_in_right;
    } t_req;

    // One result item.
    typedef struct packed {
        logic signed [MIX_W-1:0] mix_out_left;
        logic signed [MIX_W-1:0] mix_out_right;
        logic                    voice_active;
    } t_res;

    // Kind of work handed from the front end to the back end.
    typedef enum logic [1:0] {
        JOB_LOAD,
        JOB_PLAY,
        JOB_PASS
    } t_kind;

    // One job in the queue between front end and back end.
    typedef struct packed {
        t_kind                   kind;
        logic [ADDR_W-1:0]       addr;      // load address or current word
        logic [ADDR_W-1:0]       nxt_addr;  // next word
        logic                    cur_ok;    // current word lies inside the sample
        logic                    nxt_ok;    // next word lies inside the sample
        logic [WORD_W-1:0]       frac;      // position fraction, low bits used
        logic [WORD_W-1:0]       data;      // word to store
        logic signed [MIX_W-1:0] mix_l;
        logic signed [MIX_W-1:0] mix_r;
    } t_job;

endpackage

`default_nettype wire

### hdl/isv_fifo.sv
// ============================================================================
// isv_fifo: small register queue
// First-in first-out queue of any packed type, with a fill count for
// credit checks. Push and pop may happen in the same cycle.
// ============================================================================
`default_nettype none

module isv_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire T                           i_data,
    input  wire logic                       i_pop,
    output logic                            o_full,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count,
    output T                                o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### hdl/isv_front.sv
// ============================================================================
// isv_front: request classifier and play position tracker
// Decodes each accepted request, keeps the voice state and the play
// position, and turns loads and renders into jobs for the back end.
// ============================================================================
`default_nettype none

module isv_front #(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire isv_pkg::t_req                 i_req,
    input  wire logic [isv_pkg::LEN_W-1:0]     i_length,
    input  wire logic [isv_pkg::WORD_W-1:0]    i_step,
    output logic                               o_job_valid,
    output isv_pkg::t_job                      o_job
);

    localparam int F = FRAC_BITS;

    logic [31:0]    r_pos;
    logic [F-1:0]   r_frac;
    logic           r_on;
    logic [31:0]    n_pos;
    logic [F-1:0]   n_frac;
    logic           n_on;

    logic [32:0]    pos_p1;
    logic [F:0]     frac_sum;
    logic [31:0]    step_int;
    logic           ending;
    logic           cur_ok;
    logic           nxt_ok;

    // Position arithmetic for the current frame.
    assign pos_p1   = {1'b0, r_pos} + 33'd1;
    assign frac_sum = {1'b0, r_frac} + {1'b0, i_step[F-1:0]};
    assign step_int = i_step >> F;
    assign ending   = r_on && (r_pos >= 32'(i_length));
    assign cur_ok   = (r_pos < 32'(i_length)) && (r_pos < 32'(SAMPLE_DEPTH));
    assign nxt_ok   = (pos_p1 < 33'(i_length)) && (pos_p1 < 33'(SAMPLE_DEPTH));

    // Request decode and next voice state.
    always_comb begin
        n_pos        = r_pos;
        n_frac       = r_frac;
        n_on         = r_on;
        o_job_valid  = 1'b0;
        o_job        = '0;
        o_job.kind   = isv_pkg::JOB_PASS;
        o_job.mix_l  = i_req.mix_in_left;
        o_job.mix_r  = i_req.mix_in_right;
        unique case (i_req.req_type)
            isv_pkg::REQ_LOAD: begin
                o_job_valid = i_accept;
                o_job.kind  = isv_pkg::JOB_LOAD;
                o_job.addr  = i_req.load_addr;
                o_job.data  = i_req.load_data;
            end
            isv_pkg::REQ_TRIGGER: begin
                n_pos  = '0;
                n_frac = '0;
                n_on   = 1'b1;
            end
            isv_pkg::REQ_RENDER: begin
                o_job_valid = i_accept;
                if (r_on && !ending) begin
                    o_job.kind     = isv_pkg::JOB_PLAY;
                    o_job.addr     = r_pos[isv_pkg::ADDR_W-1:0];
                    o_job.nxt_addr = pos_p1[isv_pkg::ADDR_W-1:0];
                    o_job.cur_ok   = cur_ok;
                    o_job.nxt_ok   = nxt_ok;
                    o_job.frac     = isv_pkg::WORD_W'(r_frac);
                    n_pos          = r_pos + step_int + 32'(frac_sum[F]);
                    n_frac         = frac_sum[F-1:0];
                end else begin
                    n_on = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Voice state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_frac <= '0;
            r_on   <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_frac <= n_frac;
            r_on   <= n_on;
        end
    end

endmodule

`default_nettype wire

### hdl/isv_back.sv
// ============================================================================
// isv_back: sample memory and interpolation pipeline
// Takes jobs in order: loads write the sample memory, renders read two
// words, interpolate and mix into both accumulators, or pass them when idle.
// ============================================================================
`default_nettype none

module isv_back #(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int FRAC_BITS    = 16,
    parameter int OUT_DEPTH    = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_job_empty,
    input  wire isv_pkg::t_job                  i_job,
    output logic                                o_job_pop,
    input  wire logic [isv_pkg::WORD_W-1:0]     i_format_raw,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                o_res_valid,
    output isv_pkg::t_res                       o_res
);

    localparam int F   = FRAC_BITS;
    localparam int AW  = $clog2(SAMPLE_DEPTH);
    localparam int MW  = isv_pkg::MIX_W;
    localparam int PW  = MW + F + 2;
    localparam int OCW = $clog2(OUT_DEPTH+1);
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic [isv_pkg::WORD_W-1:0] r_mem [SAMPLE_DEPTH];

    logic               issue;
    logic               is_render;
    logic               credit_ok;
    logic [OCW:0]       in_use;
    logic               wr_en;
    logic [31:0]        wr_addr;
    logic [31:0]        cur_addr;
    logic [31:0]        nxt_addr;

    // Stage 1: words read from memory.
    logic                       r1_valid;
    logic                       r1_play;
    logic                       r1_cur_ok;
    logic                       r1_nxt_ok;
    logic [F-1:0]               r1_frac;
    logic signed [MW-1:0]       r1_mix_l;
    logic signed [MW-1:0]       r1_mix_r;
    logic [isv_pkg::WORD_W-1:0] r1_cur_raw;
    logic [isv_pkg::WORD_W-1:0] r1_nxt_raw;

    // Stage 2: weighted words.
    logic                 r2_valid;
    logic                 r2_play;
    logic signed [MW-1:0] r2_mix_l;
    logic signed [MW-1:0] r2_mix_r;
    logic signed [PW-1:0] r2_p_cur;
    logic signed [PW-1:0] r2_p_nxt;

    logic signed [MW-1:0] cur_s;
    logic signed [MW-1:0] nxt_s;
    logic [F:0]           w_cur;
    logic [F:0]           w_nxt;
    logic signed [PW-1:0] p_cur;
    logic signed [PW-1:0] p_nxt;
    logic [PW:0]          p_sum;
    logic signed [MW-1:0] voice;

    // Align a word of the given format to the top of the mix width, keeping its sign.
    function automatic logic signed [MW-1:0] scale_word(
        input logic [isv_pkg::WORD_W-1:0] raw,
        input logic [1:0]                 fmt
    );
        logic signed [MW-1:0] w;
        unique case (fmt)
            isv_pkg::FMT_S8:  w = {raw[7:0], {(MW-8){1'b0}}};
            isv_pkg::FMT_S16: w = {raw[15:0], {(MW-16){1'b0}}};
            default:          w = raw[isv_pkg::WORD_W-1 -: MW];
        endcase
        return w;
    endfunction

    // Add with saturation to the signed mix range.
    function automatic logic signed [MW-1:0] sat_add(
        input logic signed [MW-1:0] a,
        input logic signed [MW-1:0] b
    );
        logic [MW:0] s;
        s = {a[MW-1], a} + {b[MW-1], b};
        if (s[MW] != s[MW-1]) begin
            return s[MW] ? isv_pkg::MIX_MIN : isv_pkg::MIX_MAX;
        end
        return s[MW-1:0];
    endfunction

    // Issue: loads always go, renders only with room left in the result queue.
    assign is_render = (i_job.kind != isv_pkg::JOB_LOAD);
    assign in_use    = (OCW+1)'(i_out_count) + (OCW+1)'(r1_valid) + (OCW+1)'(r2_valid);
    assign credit_ok = in_use < (OCW+1)'(OUT_DEPTH);
    assign issue     = !i_job_empty && (!is_render || credit_ok);
    assign o_job_pop = issue;

    assign wr_addr  = 32'(i_job.addr);
    assign cur_addr = 32'(i_job.addr);
    assign nxt_addr = 32'(i_job.nxt_addr);
    assign wr_en    = issue && (i_job.kind == isv_pkg::JOB_LOAD) &&
                      (wr_addr < 32'(SAMPLE_DEPTH));

    // Sample memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= i_job.data;
        end
        if (issue) begin
            r1_cur_raw <= r_mem[cur_addr[AW-1:0]];
            r1_nxt_raw <= r_mem[nxt_addr[AW-1:0]];
        end
    end

    // Scale both words and weight them by the fraction.
    assign cur_s = r1_cur_ok ? scale_word(r1_cur_raw, i_format_raw[1:0]) : '0;
    assign nxt_s = r1_nxt_ok ? scale_word(r1_nxt_raw, i_format_raw[1:0]) : '0;
    assign w_nxt = {1'b0, r1_frac};
    assign w_cur = ONE - w_nxt;
    assign p_cur = cur_s * $signed({1'b0, w_cur});
    assign p_nxt = nxt_s * $signed({1'b0, w_nxt});

    // Sum the weighted words; the floor shift keeps the result in mix range.
    assign p_sum = {r2_p_cur[PW-1], r2_p_cur} + {r2_p_nxt[PW-1], r2_p_nxt};
    assign voice = p_sum[F+MW-1:F];

    // Mix into both accumulators or pass them through.
    always_comb begin
        o_res_valid = r2_valid;
        if (r2_play) begin
            o_res.mix_out_left  = sat_add(r2_mix_l, voice);
            o_res.mix_out_right = sat_add(r2_mix_r, voice);
        end else begin
            o_res.mix_out_left  = r2_mix_l;
            o_res.mix_out_right = r2_mix_r;
        end
        o_res.voice_active = r2_play;
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= issue && is_render;
            r2_valid <= r1_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r1_play   <= (i_job.kind == isv_pkg::JOB_PLAY);
            r1_cur_ok <= i_job.cur_ok;
            r1_nxt_ok <= i_job.nxt_ok;
            r1_frac   <= i_job.frac[F-1:0];
            r1_mix_l  <= i_job.mix_l;
            r1_mix_r  <= i_job.mix_r;
        end
        r2_play  <= r1_play;
        r2_mix_l <= r1_mix_l;
        r2_mix_r <= r1_mix_r;
        r2_p_cur <= p_cur;
        r2_p_nxt <= p_nxt;
    end

endmodule

`default_nettype wire

### hdl/interpolating_sample_voice.sv
// ============================================================================
// interpolating_sample_voice: mono sample voice with linear interpolation
// Top level: configuration registers, front end, job queue, back end and
// result queue.
// ============================================================================
// The voice takes one request per clock cycle while full is low: loads,
// triggers and renders may follow each other back to back. A render's
// result reaches the result ports through a four-entry job queue, a
// two-stage read and multiply pipeline and a four-entry result queue. The
// sample memory does one write and two reads each cycle, so a load is
// visible to a render accepted in the next cycle. Stalling the result
// side fills the queues and then raises full; the position update is one
// add in the front end, which sets the item rate of one per cycle. Sample
// memory contents are undefined after reset; only words that have been
// loaded may be played.
`default_nettype none

module interpolating_sample_voice #(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire isv_pkg::t_req                 i_req,
    output logic                               empty,
    input  wire logic                          pop,
    output isv_pkg::t_res                      o_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [isv_pkg::WORD_W-1:0]    i_cfg_data
);

    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    logic [isv_pkg::LEN_W-1:0]  r_length;
    logic [1:0]                 r_format;
    logic [isv_pkg::WORD_W-1:0] r_step;

    logic                               accept;
    logic                               job_valid;
    isv_pkg::t_job                      job_in;
    isv_pkg::t_job                      job_out;
    logic                               job_empty;
    logic                               job_pop;
    logic [$clog2(JOB_DEPTH+1)-1:0]     job_count;
    logic                               res_valid;
    isv_pkg::t_res                      res_in;
    logic                               res_full;
    logic [$clog2(OUT_DEPTH+1)-1:0]     out_count;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= isv_pkg::LENGTH_RST;
            r_format <= isv_pkg::FORMAT_RST;
            r_step   <= isv_pkg::STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                isv_pkg::CFG_LENGTH: r_length <= i_cfg_data[isv_pkg::LEN_W-1:0];
                isv_pkg::CFG_FORMAT: r_format <= i_cfg_data[1:0];
                isv_pkg::CFG_STEP:   r_step   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: request decode and play position.
    isv_front #(
        .SAMPLE_DEPTH(SAMPLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_req),
        .i_length   (r_length),
        .i_step     (r_step),
        .o_job_valid(job_valid),
        .o_job      (job_in)
    );

    // Job queue between front end and back end.
    isv_fifo #(
        .T    (isv_pkg::t_job),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_valid),
        .i_data (job_in),
        .i_pop  (job_pop),
        .o_full (full),
        .o_empty(job_empty),
        .o_count(job_count),
        .o_data (job_out)
    );

    // Back end: sample memory and interpolation.
    isv_back #(
        .SAMPLE_DEPTH(SAMPLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_format_raw(isv_pkg::WORD_W'(r_format)),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res       (res_in)
    );

    // Result queue; the back end only issues a render when a slot is free.
    isv_fifo #(
        .T    (isv_pkg::t_res),
        .DEPTH(OUT_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_data (res_in),
        .i_pop  (pop),
        .o_full (res_full),
        .o_empty(empty),
        .o_count(out_count),
        .o_data (o_res)
    );

    // A full result queue on a result push would mean a lost frame.
    logic unused_ok;
    assign unused_ok = ^{res_full, job_count};

endmodule

`default_nettype wire

### hdl/isv_checker.sv
// ============================================================================
// isv_checker: port-level checks for the interpolating sample voice
// Watches the queue handshakes on the top level over time.
// ============================================================================
`default_nettype none

module isv_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          push,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire isv_pkg::t_res o_res
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // A waiting result that is not taken stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("waiting result changed or vanished");

    // The input side only fills up from a transfer.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an input transfer");

    // A result only appears after reset once a request has passed the job queue and the pipeline registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)))
        else $error("result appeared too soon after reset");

endmodule

bind interpolating_sample_voice isv_checker u_isv_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .o_res  (o_res)
);

`default_nettype wire
